// ----- rtl/core/dcdwf_pkg.sv -----
// ----------------------------------------------------------------------------
// dcdwf_pkg
// Shared types, constants and a helper function for the DAC change-detect
// word formatter.
// ----------------------------------------------------------------------------
package dcdwf_pkg;

  localparam int CHANNELS_SEL0 = 5;
  localparam int CHANNELS_SEL1 = 6;
  localparam int CHANNEL_COUNT = CHANNELS_SEL0 + CHANNELS_SEL1;
  localparam int CH_IDX_W      = $clog2(CHANNEL_COUNT);
  localparam int MAX_PER_SEL   = 8;

  localparam int TABLE_DEPTH   = 4096;
  localparam int TABLE_AW      = $clog2(TABLE_DEPTH);

  localparam int WORD_W        = 16;

  localparam logic [3:0] CUTOFF_CHANNEL = 4'd0;
  localparam logic [15:0] LAST_SENT_RESET = 16'hFFFF;

  localparam logic OP_SAMPLE      = 1'b0;
  localparam logic OP_TABLE_WRITE = 1'b1;

  localparam logic [7:0] ADDR_SEL0 [MAX_PER_SEL] =
    '{8'h00, 8'h40, 8'h50, 8'h60, 8'h70, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] ADDR_SEL1 [MAX_PER_SEL] =
    '{8'h10, 8'h20, 8'h30, 8'h40, 8'h60, 8'h70, 8'h00, 8'h00};

  typedef struct packed {
    logic               operation;
    logic [3:0]         channel;
    logic signed [15:0] sample_value;
    logic [11:0]        table_index;
    logic [15:0]        table_word;
  } cmd_t;

  typedef struct packed {
    logic        chip_select;
    logic [15:0] dac_word;
  } word_t;

  typedef struct packed {
    logic                emit;
    logic                chip_select;
    logic                use_table;
    logic [WORD_W-1:0]   word;
    logic [TABLE_AW-1:0] table_addr;
  } dec_t;

  function automatic logic [7:0] addr_byte(input logic [3:0] channel);
    logic [4:0] local_ch;
    logic [7:0] result;
    result = 8'h00;
    if (5'(channel) < 5'(CHANNELS_SEL0)) begin
      result = ADDR_SEL0[channel[2:0]];
    end else begin
      local_ch = 5'(channel) - 5'(CHANNELS_SEL0);
      result = ADDR_SEL1[local_ch[2:0]];
    end
    return result;
  endfunction

endpackage

// ----- rtl/core/dcdwf_ram.sv -----
// ----------------------------------------------------------------------------
// dcdwf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dcdwf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/dcdwf_chan.sv -----
// ----------------------------------------------------------------------------
// dcdwf_chan
// Per-channel last-sent state, change detection and command word formatting.
// ----------------------------------------------------------------------------
module dcdwf_chan (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  dcdwf_pkg::cmd_t cmd,
  output dcdwf_pkg::dec_t dec
);

  logic [15:0] last_sent [dcdwf_pkg::CHANNEL_COUNT];

  logic                          in_range;
  logic [dcdwf_pkg::CH_IDX_W-1:0] ch_idx;
  logic                          negative;
  logic                          changed;
  logic [7:0]                    addr;
  logic [11:0]                   code;
  logic [15:0]                   store_value;

  always_comb begin
    in_range    = 5'(cmd.channel) < 5'(dcdwf_pkg::CHANNEL_COUNT);
    ch_idx      = cmd.channel[dcdwf_pkg::CH_IDX_W-1:0];
    negative    = cmd.sample_value[15];
    changed     = in_range && (last_sent[ch_idx] != 16'(cmd.sample_value));
    addr        = dcdwf_pkg::addr_byte(cmd.channel);
    code        = cmd.sample_value[14:3];
    store_value = negative ? 16'h0000 : 16'(cmd.sample_value);

    dec.emit        = (cmd.operation == dcdwf_pkg::OP_SAMPLE) && changed;
    dec.chip_select = 5'(cmd.channel) >= 5'(dcdwf_pkg::CHANNELS_SEL0);
    dec.use_table   = (cmd.channel == dcdwf_pkg::CUTOFF_CHANNEL) && !negative;
    if (negative) begin
      dec.word = {addr, 8'h00};
    end else begin
      dec.word = {addr | {4'h0, cmd.sample_value[14:11]}, cmd.sample_value[10:3]};
    end
    if ({1'b0, code} >= 13'(dcdwf_pkg::TABLE_DEPTH)) begin
      dec.table_addr = dcdwf_pkg::TABLE_AW'(dcdwf_pkg::TABLE_DEPTH - 1);
    end else begin
      dec.table_addr = code[dcdwf_pkg::TABLE_AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dcdwf_pkg::CHANNEL_COUNT; i++) begin
        last_sent[i] <= dcdwf_pkg::LAST_SENT_RESET;
      end
    end else if (accept && dec.emit) begin
      last_sent[ch_idx] <= store_value;
    end
  end

endmodule

// ----- rtl/core/dac_change_detect_word_formatter.sv -----
// ----------------------------------------------------------------------------
// dac_change_detect_word_formatter
// Drops samples equal to the value last sent on their channel and formats
// the rest into SPI command words; the cutoff channel reads a calibration table.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload  Carries
//  cmd      cmd_valid/cmd_ready    cmd      sample or calibration table write
//  word     word_valid/word_ready  word     chip select and 16-bit DAC word
//
// One transaction is accepted per cycle while no result stalls; any result it
// yields appears in the next cycle, from the output register or table RAM read.
// Reset sets every channel's last-sent value to all ones; the table is not
// cleared and must be loaded before use. A stalled result holds the output
// register and stops new transactions until it is taken.
// ----------------------------------------------------------------------------
module dac_change_detect_word_formatter (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  dcdwf_pkg::cmd_t  cmd,
  output logic             word_valid,
  input  logic             word_ready,
  output dcdwf_pkg::word_t word
);

  dcdwf_pkg::dec_t dec;
  logic            accept;
  logic            table_we;
  logic            table_re;
  logic [15:0]     table_rdata;

  logic                           out_valid;
  logic                           out_sel;
  logic                           out_use_table;
  logic [dcdwf_pkg::WORD_W-1:0]   out_word;

  assign cmd_ready = !out_valid || word_ready;
  assign accept    = cmd_valid && cmd_ready;
  assign table_we  = accept && (cmd.operation == dcdwf_pkg::OP_TABLE_WRITE) &&
                     ({1'b0, cmd.table_index} < 13'(dcdwf_pkg::TABLE_DEPTH));
  assign table_re  = accept && dec.emit && dec.use_table;

  dcdwf_chan u_chan (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .dec    (dec)
  );

  dcdwf_ram #(
    .WIDTH (16),
    .DEPTH (dcdwf_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (cmd.table_index[dcdwf_pkg::TABLE_AW-1:0]),
    .wdata (cmd.table_word),
    .re    (table_re),
    .raddr (dec.table_addr),
    .rdata (table_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_ready) begin
      out_valid <= accept && dec.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_sel       <= dec.chip_select;
      out_use_table <= dec.use_table;
      out_word      <= dec.word;
    end
  end

  assign word_valid       = out_valid;
  assign word.chip_select = out_sel;
  assign word.dac_word    = out_use_table ? table_rdata : out_word;

endmodule
